@@ rtl/psu_pkg.sv @@
package psu_pkg;

  // Default sizes of the line store and the pixel history
  localparam int MAX_ROW_BYTES_DEF   = 4096;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int BPP_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPP     = 2'd1;

  localparam logic [CFG_DATA_W-1:0] ROW_LEN_RST = 13'd4096;
  localparam logic [BPP_W-1:0]      BPP_RST     = 4'd1;

  typedef enum logic [1:0] {
    KIND_SUB   = 2'd0,
    KIND_UP    = 2'd1,
    KIND_AVG   = 2'd2,
    KIND_PAETH = 2'd3
  } filter_kind_e;

endpackage

@@ rtl/psu_ram.sv @@
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same entry is written in that cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/psu_predict.sv @@
module psu_predict (
  input  psu_pkg::filter_kind_e kind_i,
  input  logic [7:0]            data_i,
  input  logic [7:0]            left_i,
  input  logic [7:0]            above_i,
  input  logic [7:0]            upleft_i,
  output logic [7:0]            recon_o
);

  logic [8:0]        avg_sum;
  logic signed [10:0] a_s, b_s, c_s;
  logic signed [10:0] pa_s, pb_s, pc_s;
  logic [10:0]        pa, pb, pc;
  logic [7:0]         paeth;
  logic [7:0]         pred;

  assign avg_sum = {1'b0, left_i} + {1'b0, above_i};

  // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
  always_comb begin
    a_s  = signed'({3'b000, left_i});
    b_s  = signed'({3'b000, above_i});
    c_s  = signed'({3'b000, upleft_i});
    pa_s = b_s - c_s;
    pb_s = a_s - c_s;
    pc_s = a_s + b_s - c_s - c_s;
    pa   = (pa_s < 0) ? 11'(-pa_s) : 11'(pa_s);
    pb   = (pb_s < 0) ? 11'(-pb_s) : 11'(pb_s);
    pc   = (pc_s < 0) ? 11'(-pc_s) : 11'(pc_s);
    if ((pa <= pb) && (pa <= pc)) begin
      paeth = left_i;
    end else if (pb <= pc) begin
      paeth = above_i;
    end else begin
      paeth = upleft_i;
    end
  end

  always_comb begin
    case (kind_i)
      psu_pkg::KIND_SUB:   pred = left_i;
      psu_pkg::KIND_UP:    pred = above_i;
      psu_pkg::KIND_AVG:   pred = avg_sum[8:1];
      psu_pkg::KIND_PAETH: pred = paeth;
      default:             pred = left_i;
    endcase
  end

  assign recon_o = data_i + pred;

endmodule

@@ rtl/png_scanline_unfilter.sv @@
// PNG scanline reconstruction, one byte per transfer.
//
// Input channel: in_valid_i / in_stall_o carry a filtered byte, its filter kind
// (sub, up, average, paeth) and the first-row flag. Output channel:
// out_valid_o / out_stall_i carry the reconstructed byte and a row_end flag on
// the last byte of each scanline. A transfer happens on a rising edge with
// valid high and stall low.
//
// A byte goes through the read stage, then the output register. Throughput:
// one byte per cycle while the output is not stalled. The byte above is read
// from the line store (one synchronous RAM, read issued at accept, data ready
// in the next cycle); a write-back to the entry being read in the same cycle
// is forwarded, which only happens with one-byte rows. The left byte comes
// from a short register history, so consecutive bytes chain through the adder.
//
// Reset clears the position counter and both pixel histories and loads
// row_len = 4096, bytes_per_pixel = 1; the line store is not cleared, so flag
// the first row with first_row. When the receiver stalls, the output register
// holds, one more byte waits in the read stage, then in_stall_o rises until
// the output drains. Write the configuration (cfg_we_i) only while idle.
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     filtered_byte_i,
  input  logic [1:0]                     filter_kind_i,
  input  logic                           first_row_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     recon_byte_o,
  output logic                           row_end_o
);

  localparam int AW  = $clog2(MAX_ROW_BYTES);
  localparam int RAW = $clog2(MAX_ROW_BYTES + 1);
  // Width wide enough for both the configured length and the clamped length
  localparam int CLW = (RAW > psu_pkg::CFG_DATA_W) ? RAW : psu_pkg::CFG_DATA_W;
  localparam int PW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // Configuration registers
  logic [psu_pkg::CFG_DATA_W-1:0] row_len_q;
  logic [psu_pkg::BPP_W-1:0]      bpp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= psu_pkg::ROW_LEN_RST;
      bpp_q     <= psu_pkg::BPP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psu_pkg::REG_ROW_LEN: row_len_q <= cfg_wdata_i;
        psu_pkg::REG_BPP:     bpp_q     <= cfg_wdata_i[psu_pkg::BPP_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Clamp the configuration into its legal range
  logic [CLW-1:0]            row_len_ext, len_c;
  logic [psu_pkg::BPP_W-1:0] bpp_c;
  logic [PW-1:0]             hist_idx;

  always_comb begin
    row_len_ext = CLW'(row_len_q);
    if (row_len_ext == '0) begin
      len_c = CLW'(1);
    end else if (row_len_ext > CLW'(MAX_ROW_BYTES)) begin
      len_c = CLW'(MAX_ROW_BYTES);
    end else begin
      len_c = row_len_ext;
    end
    if (bpp_q == '0) begin
      bpp_c = psu_pkg::BPP_W'(1);
    end else if (bpp_q > psu_pkg::BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_c = psu_pkg::BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_c = bpp_q;
    end
    hist_idx = PW'(bpp_c - psu_pkg::BPP_W'(1));
  end

  // Handshake and stage control
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_acc;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Position counter, advanced at each input transfer
  logic [AW-1:0]  pos_q, pos_c, pos_d;
  logic [CLW-1:0] pos_full;
  logic           last_c, first_pix_c;

  always_comb begin
    if (CLW'(pos_q) >= len_c) begin
      pos_full = len_c - CLW'(1);  // length lowered mid-row: close the row here
    end else begin
      pos_full = CLW'(pos_q);
    end
    pos_c       = pos_full[AW-1:0];
    last_c      = (pos_full + CLW'(1)) >= len_c;
    first_pix_c = pos_full < CLW'(bpp_c);
    pos_d       = last_c ? '0 : pos_c + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_acc) begin
      pos_q <= pos_d;
    end
  end

  // Read stage: holds the item while the line store read completes
  logic [7:0]            s1_data_q;
  psu_pkg::filter_kind_e s1_kind_q;
  logic                  s1_first_q, s1_first_pix_q, s1_last_q;
  logic [AW-1:0]         s1_pos_q;
  logic                  fwd_q;
  logic [7:0]            fwd_data_q;
  logic [7:0]            recon;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q      <= filtered_byte_i;
      s1_kind_q      <= psu_pkg::filter_kind_e'(filter_kind_i);
      s1_first_q     <= first_row_i;
      s1_first_pix_q <= first_pix_c;
      s1_last_q      <= last_c;
      s1_pos_q       <= pos_c;
      // The entry being read is written back this same edge: forward it
      fwd_q          <= s1_adv && (s1_pos_q == pos_c);
      fwd_data_q     <= recon;
    end
  end

  // Line store of the previous reconstructed row
  logic [7:0] ram_rdata;

  psu_ram #(
    .WIDTH(8),
    .DEPTH(MAX_ROW_BYTES)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_pos_q),
    .wdata_i(recon),
    .re_i   (in_acc),
    .raddr_i(pos_c),
    .rdata_o(ram_rdata)
  );

  // Pixel histories: last reconstructed bytes and last above bytes
  logic [7:0] left_hist_q [MAX_PIXEL_BYTES];
  logic [7:0] upl_hist_q  [MAX_PIXEL_BYTES];
  logic [7:0] above, left, upleft;

  always_comb begin
    if (s1_first_q) begin
      above = 8'h00;
    end else if (fwd_q) begin
      above = fwd_data_q;
    end else begin
      above = ram_rdata;
    end
    left   = s1_first_pix_q ? 8'h00 : left_hist_q[hist_idx];
    upleft = (s1_first_pix_q || s1_first_q) ? 8'h00 : upl_hist_q[hist_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist_q[i] <= 8'h00;
        upl_hist_q[i]  <= 8'h00;
      end
    end else if (s1_adv) begin
      left_hist_q[0] <= recon;
      upl_hist_q[0]  <= above;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist_q[i] <= left_hist_q[i-1];
        upl_hist_q[i]  <= upl_hist_q[i-1];
      end
    end
  end

  psu_predict u_predict (
    .kind_i  (s1_kind_q),
    .data_i  (s1_data_q),
    .left_i  (left),
    .above_i (above),
    .upleft_i(upleft),
    .recon_o (recon)
  );

  // Output register
  logic [7:0] out_byte_q;
  logic       out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q <= recon;
      out_end_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign recon_byte_o = out_byte_q;
  assign row_end_o    = out_end_q;

endmodule

@@ dv/png_scanline_unfilter_checker.sv @@
module png_scanline_unfilter_checker
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [7:0]            filtered_byte_i,
  input  logic [1:0]            filter_kind_i,
  input  logic                  first_row_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [7:0]            recon_byte_i,
  input  logic                  row_end_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] recon_byte;
    logic       row_end;
  } recon_t;

  logic [CFG_DATA_W-1:0] row_len_q;
  logic [BPP_W-1:0]      bpp_q;
  logic [7:0]            line_mem    [MAX_ROW_BYTES];
  logic [7:0]            left_hist   [MAX_PIXEL_BYTES];
  logic [7:0]            upleft_hist [MAX_PIXEL_BYTES];
  int unsigned           pos_q;

  recon_t recon_q[$];
  recon_t want;
  int     fail_count = 0;
  int     pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic logic [7:0] paeth_select(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int est, da, db, dc;
    est = int'(a) + int'(b) - int'(c);
    da  = est - int'(a);
    db  = est - int'(b);
    dc  = est - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Reconstruct one byte and advance the row position and histories.
  function automatic recon_t unfilter_byte(logic [7:0] data, filter_kind_e kind, logic first);
    int unsigned len, bpp, pos;
    int          i;
    logic [7:0]  left, above, upleft, pred;
    logic [8:0]  sum;
    recon_t      res;
    len = (row_len_q == 0) ? 1 : ((row_len_q > MAX_ROW_BYTES) ? MAX_ROW_BYTES : row_len_q);
    bpp = (bpp_q == 0) ? 1 : ((bpp_q > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : bpp_q);
    // a row shortened mid-row ends at the current byte
    pos    = (pos_q >= len) ? len - 1 : pos_q;
    left   = (pos < bpp) ? 8'h00 : left_hist[bpp-1];
    above  = first ? 8'h00 : line_mem[pos];
    upleft = (pos < bpp || first) ? 8'h00 : upleft_hist[bpp-1];
    sum    = left + above;
    case (kind)
      KIND_SUB:   pred = left;
      KIND_UP:    pred = above;
      KIND_AVG:   pred = sum[8:1];
      default:    pred = paeth_select(left, above, upleft);
    endcase
    res.recon_byte = data + pred;
    res.row_end    = (pos + 1 >= len);
    line_mem[pos]  = res.recon_byte;
    for (i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
      left_hist[i]   = left_hist[i-1];
      upleft_hist[i] = upleft_hist[i-1];
    end
    left_hist[0]   = res.recon_byte;
    upleft_hist[0] = above;
    pos_q = res.row_end ? 0 : pos + 1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q = ROW_LEN_RST;
      bpp_q     = BPP_RST;
      pos_q     = 0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]   = 8'h00;
        upleft_hist[i] = 8'h00;
      end
      recon_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROW_LEN: row_len_q = cfg_wdata_i;
          REG_BPP:     bpp_q = cfg_wdata_i[BPP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        recon_q.push_back(unfilter_byte(filtered_byte_i, filter_kind_e'(filter_kind_i),
                                        first_row_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (recon_q.size() == 0) begin
          $error("recon_byte: expected none, actual %02h", recon_byte_i);
          fail_count++;
        end else begin
          want = recon_q.pop_front();
          if (recon_byte_i !== want.recon_byte) begin
            $error("recon_byte: expected %02h, actual %02h", want.recon_byte, recon_byte_i);
            fail_count++;
          end
          if (row_end_i !== want.row_end) begin
            $error("row_end: expected %0b, actual %0b", want.row_end, row_end_i);
            fail_count++;
          end
        end
      end
    end
    pending = recon_q.size();
  end

endmodule

@@ dv/tb_png_scanline_unfilter.sv @@
module tb_png_scanline_unfilter;
  import psu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_BYTES   = MAX_ROW_BYTES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 14;
  localparam int PHASE_BYTES = 120;

  // Indexes past the register list: writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_ROW_LEN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            filtered_byte = 8'h00;
  logic [1:0]            filter_kind = KIND_SUB;
  logic                  first_row = 1'b1;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            recon_byte;
  logic                  row_end;

  int fail_count;
  int pending;

  // Idle switches per phase, one for each side of the block.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  // Stimulus-side view of the row: where the next byte lands and which line
  // store entries already hold a byte. A byte at an entry never written must
  // carry first_row, so no read of an unwritten entry is ever caused.
  int unsigned row_pos = 0;
  int unsigned row_span = ROW_BYTES;
  bit          row_seen [ROW_BYTES];

  int unsigned cycle_count = 0;

  logic [CFG_DATA_W-1:0] len_tbl [10] = '{13'd1, 13'd2, 13'd0, 13'd8191, 13'd4096,
                                           13'd5, 13'd16, 13'd7, 13'd33, 13'd3};
  logic [BPP_W-1:0]      bpp_tbl [10] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd1,
                                           4'd3, 4'd4, 4'd6, 4'd2, 4'd8};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  png_scanline_unfilter u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .filtered_byte_i (filtered_byte),
    .filter_kind_i   (filter_kind),
    .first_row_i     (first_row),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .recon_byte_o    (recon_byte),
    .row_end_o       (row_end)
  );

  png_scanline_unfilter_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .filtered_byte_i (filtered_byte),
    .filter_kind_i   (filter_kind),
    .first_row_i     (first_row),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .recon_byte_i    (recon_byte),
    .row_end_i       (row_end),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one byte and hold it until the transfer. Valid drops only when a
  // gap is drawn, so back-to-back bytes keep it high without a glitch.
  task automatic send_byte(input logic [7:0] data, input filter_kind_e kind,
                           input logic first);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    filtered_byte <= data;
    filter_kind   <= kind;
    first_row     <= first;
    do @(posedge clk); while (in_stall);
  endtask

  // Send a byte and advance the row view; force first_row at unwritten entries.
  task automatic feed_byte(input logic [7:0] data, input filter_kind_e kind,
                           input logic first);
    int unsigned slot;
    slot = (row_pos >= row_span) ? row_span - 1 : row_pos;
    send_byte(data, kind, first || !row_seen[slot]);
    row_seen[slot] = 1'b1;
    row_pos = (slot + 1 >= row_span) ? 0 : slot + 1;
  endtask

  // Write both registers back to back, plus one spare index if asked.
  // Write enable stays high across the writes and drops once at the end.
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] len_word,
                              input logic [BPP_W-1:0] bpp, input bit spare);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_ROW_LEN;
    cfg_wdata <= len_word;
    @(posedge clk);
    cfg_idx   <= REG_BPP;
    // junk in the upper bits is masked off by the block
    cfg_wdata <= {(CFG_DATA_W-BPP_W)'($urandom), bpp};
    @(posedge clk);
    if (spare) begin
      cfg_idx   <= ($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    row_span = (len_word == 0) ? 1 : ((len_word > ROW_BYTES) ? ROW_BYTES : len_word);
  endtask

  // Drop valid and hold until every reconstructed byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Mostly well-formed rows: one filter kind and one first_row per row, with
  // random content. One byte in sixteen breaks the row with a random kind
  // and flag; extreme data values show up often.
  task automatic run_rows(input int count);
    filter_kind_e kind;
    logic         row_first;
    logic [7:0]   data;
    int           pick;
    kind      = filter_kind_e'($urandom_range(0, 3));
    row_first = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (row_pos == 0) begin
        kind      = filter_kind_e'($urandom_range(0, 3));
        row_first = ($urandom_range(0, 5) == 0);
      end
      pick = $urandom_range(0, 15);
      data = (pick == 0) ? 8'h00 : ((pick == 1) ? 8'hFF : 8'($urandom));
      if (pick == 2)
        feed_byte(data, filter_kind_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      else
        feed_byte(data, kind, row_first);
    end
  endtask

  // Receiver: draw a stall length per result, then wait for the transfer.
  initial begin
    int hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = rx_idle_on ? $urandom_range(0, 14) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first bytes under reset geometry, all flagged as first row.
    feed_byte(8'h00, KIND_SUB,   1'b1);
    feed_byte(8'hFF, KIND_SUB,   1'b1);
    feed_byte(8'h80, KIND_UP,    1'b1);
    feed_byte(8'h7F, KIND_AVG,   1'b1);
    feed_byte(8'hFF, KIND_PAETH, 1'b1);
    feed_byte(8'h01, KIND_AVG,   1'b1);
    drain();

    // Shrink the row below the current position: the next byte ends the row.
    set_geometry(13'd3, 4'd1, 1'b1);
    feed_byte(8'h55, KIND_UP, 1'b0);
    // Full rows over a written line store, each kind with extreme data.
    feed_byte(8'hFF, KIND_UP,    1'b0);
    feed_byte(8'hFF, KIND_UP,    1'b0);
    feed_byte(8'h01, KIND_UP,    1'b0);
    feed_byte(8'h00, KIND_AVG,   1'b0);
    feed_byte(8'hFF, KIND_AVG,   1'b0);
    feed_byte(8'h80, KIND_AVG,   1'b0);
    feed_byte(8'hFF, KIND_PAETH, 1'b0);
    feed_byte(8'h00, KIND_PAETH, 1'b0);
    feed_byte(8'h7F, KIND_PAETH, 1'b0);
    feed_byte(8'h01, KIND_SUB,   1'b0);
    feed_byte(8'hFF, KIND_SUB,   1'b0);
    feed_byte(8'hFF, KIND_SUB,   1'b0);
    // Toggle first_row inside a row.
    feed_byte(8'h10, KIND_PAETH, 1'b1);
    feed_byte(8'h20, KIND_PAETH, 1'b0);
    feed_byte(8'h30, KIND_PAETH, 1'b1);
    drain();

    // Random phases: table of extremes first (row of one byte, clamped
    // lengths and pixel sizes), then random small geometries. Cycle the
    // idle pattern so each side runs both with gaps and flat out.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      mode       = phase % 4;
      tx_idle_on = (mode == 0 || mode == 1);
      rx_idle_on = (mode == 0 || mode == 2);
      if (phase < 10)
        set_geometry(len_tbl[phase], bpp_tbl[phase], (phase % 3) == 0);
      else
        set_geometry(CFG_DATA_W'($urandom_range(1, 40)), BPP_W'($urandom_range(0, 15)),
                     (phase % 3) == 0);
      run_rows(PHASE_BYTES);
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
